// File: src/krat_pkg.sv
// Package for the keyed route aggregation table: item types, status codes,
// sequencer states and helper functions. Depends on nothing.
package krat_pkg;

  localparam int unsigned CodeW   = 24;
  localparam int unsigned CountW  = 32;
  localparam int unsigned Months  = 6;
  localparam logic [7:0]  UpperLo = 8'd65;
  localparam logic [7:0]  UpperHi = 8'd90;
  localparam logic [1:0]  AirlineLetters = 2'd2;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_ROUTE   = 2'd0,
    KIND_ORIGIN  = 2'd1,
    KIND_DEST    = 2'd2,
    KIND_AIRLINE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_ACCUM    = 3'd1,
    ST_BAD      = 3'd2,
    ST_FULL     = 3'd3,
    ST_MATCH    = 3'd4,
    ST_FOUND    = 3'd5,
    ST_INCONCL  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MONTH,
    S_EMIT,
    S_TOTAL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [0:0]        opcode;
    logic [1:0]        search_kind;
    logic [CodeW-1:0]  origin;
    logic [CodeW-1:0]  destination;
    logic [CodeW-1:0]  airline;
    logic [2:0]        month;
    logic [CodeW-1:0]  travellers;
    logic [CodeW-1:0]  key_first;
    logic [CodeW-1:0]  key_second;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               last;
    logic [CodeW-1:0]   match_airline;
    logic [CodeW-1:0]   match_origin;
    logic [CodeW-1:0]   match_destination;
    logic [CountW-1:0]  sum_month0;
    logic [CountW-1:0]  sum_month1;
    logic [CountW-1:0]  sum_month2;
    logic [CountW-1:0]  sum_month3;
    logic [CountW-1:0]  sum_month4;
    logic [CountW-1:0]  sum_month5;
    logic [CountW-1:0]  grand_total;
  } out_item_t;

  // Airline code is valid when exactly two bytes of its zero-terminated
  // string are uppercase letters.
  function automatic logic airline_ok(logic [CodeW-1:0] code);
    logic [1:0] upper;
    logic       ended;
    logic [7:0] ch;
    upper = '0;
    ended = 1'b0;
    for (int k = 2; k >= 0; k--) begin
      ch = code[8*k +: 8];
      if (ch == 8'd0) ended = 1'b1;
      if (!ended && ch >= UpperLo && ch <= UpperHi) upper = upper + 2'd1;
    end
    return upper == AirlineLetters;
  endfunction

endpackage

// File: src/krat_sat_adder.sv
// Shared saturating 32-bit adder used for every accumulation in the table.
// Depends on krat_pkg.
module krat_sat_adder import krat_pkg::*; (
  input  logic [CountW-1:0] a_i,
  input  logic [CountW-1:0] b_i,
  output logic [CountW-1:0] sum_o
);
  logic [CountW:0] full;
  assign full  = {1'b0, a_i} + {1'b0, b_i};
  assign sum_o = full[CountW] ? '1 : full[CountW-1:0];
endmodule

// File: src/keyed_route_aggregation_table.sv
// Keyed route aggregation table top level: key store, count memory and the
// scanning sequencer around one shared saturating adder. Depends on krat_pkg and krat_sat_adder.
//
// Each item scans the table one entry per cycle while no match is being
// handled, starting in the cycle after it is accepted. A malformed insert
// (bad airline code or month) skips the scan. A well-formed insert compares
// one entry per cycle up to its match, or over all valid entries when none
// matches. A match then reads the count and writes back the saturated sum.
// An append starts a sweep that writes the new entry's six counts, and the
// input stays stalled until the sweep ends. A search scans all valid
// entries. Each matching entry adds a memory read and an add through the
// one shared adder for each month, and then loads its match item. The grand
// total is then summed from the six month sums through the same adder.
// Every item ends by loading its final result item, and the block is ready
// again in the cycle after that unless an append sweep is still running.
// Output stall keeps the input stalled longer.
// Count memory reset: the six counts of an entry are written when that entry
// is appended, the inserted count at its month and zero elsewhere, and only
// entries below the fill count are ever read, so no clearing pass is needed.
// Results wait in one output register while stall is high.
module keyed_route_aggregation_table import krat_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned MemD = TABLE_ENTRIES * Months;
  localparam int unsigned AddrW = $clog2(MemD);

  // Key store, one entry read per cycle at the scan index.
  logic [CodeW-1:0] key_org_q [TABLE_ENTRIES];
  logic [CodeW-1:0] key_dst_q [TABLE_ENTRIES];
  logic [CodeW-1:0] key_air_q [TABLE_ENTRIES];
  logic [CountW-1:0] cnt_mem [MemD];

  state_e            state_q, state_d;
  in_item_t          item_q;
  logic [CntW-1:0]   fill_q;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [2:0]        mon_q, mon_d;
  logic [CountW-1:0] sums_q [Months];
  logic [CountW-1:0] total_q;
  logic [CountW-1:0] rd_q;
  logic              rd_ok_q;
  logic              out_valid_q;
  out_item_t         out_q, out_d;
  status_e           status_q;
  logic              out_free;

  logic [IdxW-1:0]   idx;
  logic              hit, key_eq;
  logic [CountW-1:0] add_a, add_b, add_s;
  logic [AddrW-1:0]  rd_addr;
  logic              mem_we;
  logic [AddrW-1:0]  wr_addr;
  logic [CountW-1:0] wr_data;
  logic [2:0]        clr_q;
  logic              clr_busy_q;
  logic [IdxW-1:0]   clr_row_q;

  assign idx = idx_q[IdxW-1:0];
  assign in_stall_o  = (state_q != S_IDLE) || clr_busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    key_eq = key_org_q[idx] == item_q.origin && key_dst_q[idx] == item_q.destination &&
             key_air_q[idx] == item_q.airline;
    case (kind_e'(item_q.search_kind))
      KIND_ROUTE:  hit = key_org_q[idx] == item_q.key_first &&
                         key_dst_q[idx] == item_q.key_second;
      KIND_ORIGIN: hit = key_org_q[idx] == item_q.key_first;
      KIND_DEST:   hit = key_dst_q[idx] == item_q.key_first;
      default:     hit = key_air_q[idx] == item_q.key_first;
    endcase
  end

  // Memory read address: entry row plus month.
  always_comb begin
    if (item_q.opcode == OP_INSERT)
      rd_addr = AddrW'(idx * Months + item_q.month);
    else
      rd_addr = AddrW'(idx * Months + mon_q);
  end

  // Shared adder operand selection.
  always_comb begin
    if (state_q == S_TOTAL) begin
      add_a = total_q;
      add_b = sums_q[mon_q];
    end else if (item_q.opcode == OP_INSERT) begin
      add_a = rd_q;
      add_b = CountW'(item_q.travellers);
    end else begin
      add_a = sums_q[mon_q];
      add_b = rd_q;
    end
  end

  krat_sat_adder u_add (.a_i(add_a), .b_i(add_b), .sum_o(add_s));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    mon_d   = mon_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          idx_d = '0;
          mon_d = '0;
          if (in_data_i.opcode == OP_INSERT &&
              (!airline_ok(in_data_i.airline) || in_data_i.month >= 3'(Months)))
            state_d = S_DONE;
          else
            state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q >= fill_q) begin
          if (item_q.opcode == OP_INSERT) state_d = S_DONE;
          else begin
            state_d = S_TOTAL;
            mon_d   = '0;
          end
        end else if (item_q.opcode == OP_INSERT ? key_eq : hit) begin
          state_d = S_MONTH;
          mon_d   = '0;
        end else idx_d = idx_q + CntW'(1);
      end
      S_MONTH: begin
        // Cycle with mon_q read issued; rd_ok_q tells data has arrived.
        if (rd_ok_q) begin
          if (item_q.opcode == OP_INSERT) state_d = S_DONE;
          else if (mon_q == 3'(Months - 1)) state_d = S_EMIT;
          else mon_d = mon_q + 3'd1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_SCAN;
          idx_d   = idx_q + CntW'(1);
        end
      end
      S_TOTAL: begin
        if (mon_q == 3'(Months - 1)) state_d = S_DONE;
        else mon_d = mon_q + 3'd1;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory write: the append sweep or an accumulation.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = AddrW'(clr_row_q * Months + clr_q);
    wr_data = '0;
    if (clr_busy_q) begin
      mem_we = 1'b1;
      if (clr_q == item_q.month) wr_data = CountW'(item_q.travellers);
    end else if (state_q == S_MONTH && item_q.opcode == OP_INSERT && rd_ok_q) begin
      mem_we  = 1'b1;
      wr_addr = rd_addr;
      wr_data = add_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) cnt_mem[wr_addr] <= wr_data;
    rd_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      mon_q       <= '0;
      fill_q      <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      clr_busy_q  <= 1'b0;
      clr_q       <= '0;
      clr_row_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      mon_q   <= mon_d;
      rd_ok_q <= (state_q == S_MONTH) && !rd_ok_q;
      if ((state_q == S_EMIT || state_q == S_DONE) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (clr_busy_q) begin
        if (clr_q == 3'(Months - 1)) begin
          clr_busy_q <= 1'b0;
          clr_q      <= '0;
        end else clr_q <= clr_q + 3'd1;
      end
      // Insert with no match and room: append, then sweep its six counts,
      // writing the inserted count at its month and zero elsewhere.
      if (state_q == S_SCAN && item_q.opcode == OP_INSERT && idx_q >= fill_q &&
          fill_q < CntW'(TABLE_ENTRIES)) begin
        fill_q     <= fill_q + CntW'(1);
        clr_busy_q <= 1'b1;
        clr_row_q  <= idx;
        clr_q      <= '0;
      end
    end
  end

  // Next result item: a match item while emitting, else the final item.
  always_comb begin
    out_d = '0;
    if (state_q == S_EMIT) begin
      out_d.status            = ST_MATCH;
      out_d.match_airline     = key_air_q[idx];
      out_d.match_origin      = key_org_q[idx];
      out_d.match_destination = key_dst_q[idx];
    end else begin
      out_d.last = 1'b1;
      if (item_q.opcode == OP_SEARCH) begin
        out_d.status      = (total_q != '0) ? ST_FOUND : ST_INCONCL;
        out_d.sum_month0  = sums_q[0];
        out_d.sum_month1  = sums_q[1];
        out_d.sum_month2  = sums_q[2];
        out_d.sum_month3  = sums_q[3];
        out_d.sum_month4  = sums_q[4];
        out_d.sum_month5  = sums_q[5];
        out_d.grand_total = total_q;
      end else begin
        out_d.status = status_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && !in_stall_o) begin
      item_q   <= in_data_i;
      total_q  <= '0;
      for (int m = 0; m < Months; m++) sums_q[m] <= '0;
      status_q <= ST_BAD;
    end
    if (state_q == S_SCAN && item_q.opcode == OP_INSERT && idx_q >= fill_q) begin
      if (fill_q < CntW'(TABLE_ENTRIES)) begin
        key_org_q[idx] <= item_q.origin;
        key_dst_q[idx] <= item_q.destination;
        key_air_q[idx] <= item_q.airline;
        status_q       <= ST_NEW;
      end else status_q <= ST_FULL;
    end
    if (state_q == S_MONTH && rd_ok_q) begin
      if (item_q.opcode == OP_INSERT) status_q <= ST_ACCUM;
      else sums_q[mon_q] <= add_s;
    end
    if (state_q == S_TOTAL) total_q <= add_s;
    if ((state_q == S_EMIT || state_q == S_DONE) && out_free) out_q <= out_d;
  end

endmodule

// File: src/krat_checker.sv
// Port-level checker for the keyed route aggregation table, bound to the
// top level. Depends on krat_pkg.
module krat_checker import krat_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed");
  a_match_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_MATCH |-> !out_data_o.last)
    else $error("match item flagged last");
  a_busy_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("ready again right after accept");
  a_inconcl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_INCONCL |-> out_data_o.grand_total == '0)
    else $error("inconclusive with nonzero total");
endmodule

bind keyed_route_aggregation_table krat_checker u_krat_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o));
